// ----- rtl/urxf_pkg.sv -----
`timescale 1ns / 1ps

package urxf_pkg;

    localparam int TIMER_W       = 20;
    localparam int COUNT_W       = TIMER_W + 1;
    localparam int MAX_DATA_BITS = 16;
    localparam int SHIFT_W       = MAX_DATA_BITS + 1;
    localparam int FIFO_AW       = 4;
    localparam int FIFO_DEPTH    = 1 << FIFO_AW;
    localparam int IN_W          = 8;
    localparam int OUT_W         = 32;

    localparam logic [1:0] ERR_FRAMING = 2'h1;
    localparam logic [1:0] ERR_PARITY  = 2'h2;

    typedef enum logic [2:0] {
        REG_TICKS_PER_BIT    = 3'd0,
        REG_DATA_BITS        = 3'd1,
        REG_PARITY_ENABLE    = 3'd2,
        REG_PARITY_ODD       = 3'd3,
        REG_IRQ_LEVEL        = 3'd4,
        REG_RTS_ENABLE       = 3'd5,
        REG_RTS_HALT_LEVEL   = 3'd6,
        REG_RTS_RESUME_LEVEL = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [TIMER_W-1:0] ticks_per_bit;
        logic [4:0]         data_bits;
        logic               parity_enable;
        logic               parity_odd;
        logic [3:0]         irq_level;
        logic               rts_enable;
        logic [3:0]         rts_halt_level;
        logic [3:0]         rts_resume_level;
    } cfg_t;

    typedef struct packed {
        logic                     valid;
        logic [1:0]               errors;
        logic [MAX_DATA_BITS-1:0] data;
    } push_t;

    typedef struct packed {
        logic                     word_done;
        logic                     rts_out;
        logic                     level_irq;
        logic                     overrun_flag;
        logic [FIFO_AW-1:0]       fill_level;
        logic                     fifo_not_empty;
        logic [1:0]               head_errors;
        logic [MAX_DATA_BITS-1:0] head_data;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    function automatic logic [4:0] clamp_bits(input logic [4:0] bits);
        clamp_bits = (bits > 5'(MAX_DATA_BITS)) ? 5'(MAX_DATA_BITS) : bits;
    endfunction

endpackage

// ----- rtl/urxf_deframer.sv -----
`timescale 1ns / 1ps

module urxf_deframer
    import urxf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  tick,
    input  logic  rx_level,
    output push_t push
);

    logic               receiving_reg, receiving_next;
    logic               prev_level_reg;
    logic [COUNT_W-1:0] countdown_reg, countdown_next;
    logic [4:0]         bits_left_reg, bits_left_next;
    logic [4:0]         bit_pos_reg, bit_pos_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic               parity_reg, parity_next;

    logic [COUNT_W-1:0] start_count;
    logic [COUNT_W-1:0] bit_count;
    logic [COUNT_W-1:0] count_dec;
    logic [4:0]         width;
    logic [SHIFT_W-1:0] mask;

    assign width       = clamp_bits(cfg.data_bits);
    assign start_count = {1'b0, cfg.ticks_per_bit} + {2'b0, cfg.ticks_per_bit[TIMER_W-1:1]};
    assign bit_count   = (cfg.ticks_per_bit == '0) ? COUNT_W'(1) : {1'b0, cfg.ticks_per_bit};
    assign count_dec   = (countdown_reg != '0) ? countdown_reg - COUNT_W'(1) : '0;
    assign mask        = (SHIFT_W'(1) << width) - SHIFT_W'(1);

    always_comb
    begin
        receiving_next = receiving_reg;
        countdown_next = countdown_reg;
        bits_left_next = bits_left_reg;
        bit_pos_next   = bit_pos_reg;
        shift_next     = shift_reg;
        parity_next    = parity_reg;
        push.valid     = 1'b0;
        push.errors    = '0;
        push.data      = shift_reg[MAX_DATA_BITS-1:0] & mask[MAX_DATA_BITS-1:0];
        if (!receiving_reg)
        begin
            if (prev_level_reg && !rx_level)
            begin
                receiving_next = 1'b1;
                countdown_next = (start_count == '0) ? COUNT_W'(1) : start_count;
                bits_left_next = width + 5'(cfg.parity_enable);
                bit_pos_next   = '0;
                shift_next     = '0;
                parity_next    = cfg.parity_enable & cfg.parity_odd;
            end
        end
        else
        begin
            countdown_next = count_dec;
            if (count_dec == '0)
            begin
                if (bits_left_reg == '0)
                begin
                    // stop bit
                    receiving_next = 1'b0;
                    push.valid     = 1'b1;
                    if (!rx_level)
                    begin
                        push.errors = push.errors | ERR_FRAMING;
                    end
                    if (cfg.parity_enable && parity_reg)
                    begin
                        push.errors = push.errors | ERR_PARITY;
                    end
                end
                else
                begin
                    bits_left_next = bits_left_reg - 5'd1;
                    if (rx_level)
                    begin
                        if (bit_pos_reg <= 5'(MAX_DATA_BITS))
                        begin
                            shift_next = shift_reg | (SHIFT_W'(1) << bit_pos_reg);
                        end
                        parity_next = ~parity_reg;
                    end
                    if (bit_pos_reg <= 5'(MAX_DATA_BITS))
                    begin
                        bit_pos_next = bit_pos_reg + 5'd1;
                    end
                    countdown_next = bit_count;
                end
            end
        end
        if (!tick)
        begin
            push.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg  <= 1'b0;
            prev_level_reg <= 1'b1;
            countdown_reg  <= '0;
            bits_left_reg  <= '0;
            bit_pos_reg    <= '0;
            shift_reg      <= '0;
            parity_reg     <= 1'b0;
        end
        else if (tick)
        begin
            receiving_reg  <= receiving_next;
            prev_level_reg <= rx_level;
            countdown_reg  <= countdown_next;
            bits_left_reg  <= bits_left_next;
            bit_pos_reg    <= bit_pos_next;
            shift_reg      <= shift_next;
            parity_reg     <= parity_next;
        end
    end

endmodule

// ----- rtl/urxf_fifo.sv -----
`timescale 1ns / 1ps

module urxf_fifo
    import urxf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    tick,
    input  logic    pop_request,
    input  push_t   push,
    output result_t result
);

    localparam logic [FIFO_AW-1:0] FULL_LEVEL = FIFO_AW'(FIFO_DEPTH - 1);

    logic [MAX_DATA_BITS+1:0] store [FIFO_DEPTH];

    logic [FIFO_AW-1:0] wr_reg, wr_next;
    logic [FIFO_AW-1:0] rd_reg, rd_next;
    logic               overrun_reg, overrun_next;
    logic               rts_reg, rts_next;

    logic [FIFO_AW-1:0] fill_pre, fill_mid, fill_post;
    logic               do_pop, do_push;
    logic               rts_mid;
    logic [MAX_DATA_BITS+1:0] head;

    always_comb
    begin
        fill_pre = wr_reg - rd_reg;
        do_pop   = pop_request && (fill_pre != '0);
        rd_next  = rd_reg + FIFO_AW'(do_pop);
        fill_mid = wr_reg - rd_next;

        rts_mid = rts_reg;
        if (do_pop && cfg.rts_enable)
        begin
            priority if (fill_mid >= cfg.rts_halt_level)
                rts_mid = 1'b1;
            else if (fill_mid <= cfg.rts_resume_level)
                rts_mid = 1'b0;
            else
                rts_mid = rts_reg;
        end

        do_push      = push.valid && (fill_mid != FULL_LEVEL);
        overrun_next = overrun_reg | (push.valid && (fill_mid == FULL_LEVEL));
        wr_next      = wr_reg + FIFO_AW'(do_push);
        fill_post    = fill_mid + FIFO_AW'(do_push);

        rts_next = rts_mid;
        if (do_push && cfg.rts_enable)
        begin
            priority if (fill_post >= cfg.rts_halt_level)
                rts_next = 1'b1;
            else if (fill_post <= cfg.rts_resume_level)
                rts_next = 1'b0;
            else
                rts_next = rts_mid;
        end

        // a push into an empty FIFO becomes the head right away
        if (fill_post == '0)
            head = '0;
        else if (do_push && (wr_reg == rd_next))
            head = {push.errors, push.data};
        else
            head = store[rd_next];

        result.head_data      = head[MAX_DATA_BITS-1:0];
        result.head_errors    = head[MAX_DATA_BITS+1:MAX_DATA_BITS];
        result.fifo_not_empty = (fill_post != '0);
        result.fill_level     = fill_post;
        result.overrun_flag   = overrun_next;
        result.level_irq      = do_push && (fill_post == cfg.irq_level);
        result.rts_out        = cfg.rts_enable & rts_next;
        result.word_done      = push.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick && do_push)
        begin
            store[wr_reg] <= {push.errors, push.data};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg      <= '0;
            rd_reg      <= '0;
            overrun_reg <= 1'b0;
            rts_reg     <= 1'b0;
        end
        else if (tick)
        begin
            wr_reg      <= wr_next;
            rd_reg      <= rd_next;
            overrun_reg <= overrun_next;
            rts_reg     <= rts_next;
        end
    end

endmodule

// ----- rtl/urxf_skid.sv -----
`timescale 1ns / 1ps

module urxf_skid
    import urxf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [OUT_W-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data
);

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic [OUT_W-1:0] skid_data_reg;
    logic             in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ----- rtl/uart_receiver_with_fifo_rts.sv -----
`timescale 1ns / 1ps

// UART receiver with a 16-slot receive FIFO (15 usable entries) and RTS flow control.
// s_* : one beat per timer tick. s_tdata[0] = sampled RX level, s_tdata[1] = host pop.
// m_* : one status beat per input beat, showing the state after that tick: head entry,
//       fill level, sticky overrun, level interrupt pulse, RTS pin and word-done pulse.
// cfg_*: register write, index 0..7 as ticks_per_bit, data_bits, parity_enable,
//       parity_odd, irq_level, rts_enable, rts_halt_level, rts_resume_level.
//       Write only while no tick is in flight.
// A tick's status is registered in the output register, or the skid register on a stall.
// Throughput: one tick per cycle while s_tready is high; the whole tick update sits
// between the receiver/FIFO state registers and the output register, with no iteration.
// A two-beat output stage (output register plus skid register) keeps s_tready high while a
// single result waits; s_tready drops only when two results are held back by m_tready.
// The tick pipeline simply freezes while s_tready is low; no tick is lost or repeated.
// Reset: configuration returns to its defaults, receiver idle with the line assumed high,
// FIFO empty, overrun and RTS state cleared, output stage empty. No clearing pass.
module uart_receiver_with_fifo_rts
    import urxf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [TIMER_W-1:0] cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_W-1:0]    s_tdata,   // [0] rx_level, [1] pop_request, rest zero
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata    // [15:0] head_data, [17:16] head_errors,
                                          // [18] fifo_not_empty, [22:19] fill_level,
                                          // [23] overrun_flag, [24] level_irq,
                                          // [25] rts_out, [26] word_done, rest zero
);

    cfg_t    cfg_reg;
    logic    tick;
    push_t   push;
    result_t result;

    assign tick = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_bit    <= TIMER_W'(16);
            cfg_reg.data_bits        <= 5'd8;
            cfg_reg.parity_enable    <= 1'b0;
            cfg_reg.parity_odd       <= 1'b0;
            cfg_reg.irq_level        <= 4'd1;
            cfg_reg.rts_enable       <= 1'b0;
            cfg_reg.rts_halt_level   <= 4'd12;
            cfg_reg.rts_resume_level <= 4'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_TICKS_PER_BIT:    cfg_reg.ticks_per_bit    <= cfg_data;
                REG_DATA_BITS:        cfg_reg.data_bits        <= cfg_data[4:0];
                REG_PARITY_ENABLE:    cfg_reg.parity_enable    <= cfg_data[0];
                REG_PARITY_ODD:       cfg_reg.parity_odd       <= cfg_data[0];
                REG_IRQ_LEVEL:        cfg_reg.irq_level        <= cfg_data[3:0];
                REG_RTS_ENABLE:       cfg_reg.rts_enable       <= cfg_data[0];
                REG_RTS_HALT_LEVEL:   cfg_reg.rts_halt_level   <= cfg_data[3:0];
                REG_RTS_RESUME_LEVEL: cfg_reg.rts_resume_level <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    urxf_deframer u_deframer (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .tick     (tick),
        .rx_level (s_tdata[0]),
        .push     (push)
    );

    urxf_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .tick        (tick),
        .pop_request (s_tdata[1]),
        .push        (push),
        .result      (result)
    );

    urxf_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   ({(OUT_W - RESULT_W)'(0), result}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // backpressure only when two results are held
    assert property (@(posedge clk) disable iff (!rst_n) !s_tready |-> m_tvalid)
        else $error("input stalled with empty output stage");

    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid && m_tdata[24] |-> m_tdata[26])
        else $error("level interrupt without a finished word");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[18] == (m_tdata[22:19] != 4'd0)))
        else $error("not-empty flag disagrees with fill level");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[18] |-> (m_tdata[17:0] == 18'd0))
        else $error("head fields not zero on empty FIFO");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import urxf_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LONG  = 300;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [TIMER_W-1:0] cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;

    uart_receiver_with_fifo_rts dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // receiver/FIFO mirror
    cfg_t                     cfg_m;
    logic                     rx_busy;
    logic                     line_q;
    logic [COUNT_W-1:0]       countdown;
    logic [4:0]               bits_left;
    logic [4:0]               bit_pos;
    logic [SHIFT_W-1:0]       shreg;
    logic                     par_acc;
    logic [MAX_DATA_BITS+1:0] fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]       wr_ptr;
    logic [FIFO_AW-1:0]       rd_ptr;
    logic                     overrun_q;
    logic                     rts_q;

    result_t pending_status[$];
    int      mismatch_count;
    int      idle_cycles;
    int      ticks_sent;
    int      send_mode;
    int      recv_mode;
    int      hold_cycles;

    always #6 clk = ~clk;

    function automatic logic [4:0] eff_bits(input logic [4:0] b);
        return (b > 5'(MAX_DATA_BITS)) ? 5'(MAX_DATA_BITS) : b;
    endfunction

    function automatic void rts_eval(input logic [FIFO_AW-1:0] fill);
        if (cfg_m.rts_enable)
        begin
            if (fill >= cfg_m.rts_halt_level)
                rts_q = 1'b1;
            else if (fill <= cfg_m.rts_resume_level)
                rts_q = 1'b0;
        end
    endfunction

    function automatic void reset_model();
        cfg_m.ticks_per_bit    = 20'd16;
        cfg_m.data_bits        = 5'd8;
        cfg_m.parity_enable    = 1'b0;
        cfg_m.parity_odd       = 1'b0;
        cfg_m.irq_level        = 4'd1;
        cfg_m.rts_enable       = 1'b0;
        cfg_m.rts_halt_level   = 4'd12;
        cfg_m.rts_resume_level = 4'd4;
        rx_busy   = 1'b0;
        line_q    = 1'b1;
        countdown = '0;
        bits_left = '0;
        bit_pos   = '0;
        shreg     = '0;
        par_acc   = 1'b0;
        wr_ptr    = '0;
        rd_ptr    = '0;
        overrun_q = 1'b0;
        rts_q     = 1'b0;
        foreach (fifo_mem[i])
            fifo_mem[i] = '0;
    endfunction

    // status after one timer tick
    function automatic result_t next_status(input logic rx, input logic pop);
        logic [COUNT_W-1:0]       reload;
        logic [FIFO_AW-1:0]       fill;
        logic [1:0]               err;
        logic [MAX_DATA_BITS:0]   mask;
        logic [MAX_DATA_BITS+1:0] head;
        logic                     irq;
        logic                     done;
        result_t                  r;
        irq  = 1'b0;
        done = 1'b0;
        if (pop && wr_ptr != rd_ptr)
        begin
            rd_ptr = rd_ptr + FIFO_AW'(1);
            rts_eval(wr_ptr - rd_ptr);
        end
        if (!rx_busy)
        begin
            if (line_q && !rx)
            begin
                reload = COUNT_W'(cfg_m.ticks_per_bit) + COUNT_W'(cfg_m.ticks_per_bit >> 1);
                rx_busy   = 1'b1;
                countdown = (reload == '0) ? COUNT_W'(1) : reload;
                bits_left = eff_bits(cfg_m.data_bits) + 5'(cfg_m.parity_enable);
                bit_pos   = '0;
                shreg     = '0;
                par_acc   = cfg_m.parity_enable & cfg_m.parity_odd;
            end
        end
        else
        begin
            if (countdown != '0)
                countdown = countdown - COUNT_W'(1);
            if (countdown == '0)
            begin
                if (bits_left == '0)
                begin
                    done    = 1'b1;
                    rx_busy = 1'b0;
                    err     = '0;
                    if (!rx)
                        err = err | ERR_FRAMING;
                    if (cfg_m.parity_enable && par_acc)
                        err = err | ERR_PARITY;
                    mask = (17'd1 << eff_bits(cfg_m.data_bits)) - 17'd1;
                    fill = wr_ptr - rd_ptr;
                    if (fill >= FIFO_AW'(FIFO_DEPTH - 1))
                        overrun_q = 1'b1;
                    else
                    begin
                        fifo_mem[wr_ptr] = {err, shreg[MAX_DATA_BITS-1:0]
                                                 & mask[MAX_DATA_BITS-1:0]};
                        wr_ptr = wr_ptr + FIFO_AW'(1);
                        fill   = fill + FIFO_AW'(1);
                        if (fill == cfg_m.irq_level)
                            irq = 1'b1;
                        rts_eval(fill);
                    end
                end
                else
                begin
                    bits_left = bits_left - 5'd1;
                    if (rx)
                    begin
                        if (bit_pos <= 5'(MAX_DATA_BITS))
                            shreg[bit_pos] = 1'b1;
                        par_acc = ~par_acc;
                    end
                    if (bit_pos <= 5'(MAX_DATA_BITS))
                        bit_pos = bit_pos + 5'd1;
                    countdown = (cfg_m.ticks_per_bit == '0) ? COUNT_W'(1)
                                                            : COUNT_W'(cfg_m.ticks_per_bit);
                end
            end
        end
        line_q = rx;
        fill   = wr_ptr - rd_ptr;
        head   = (fill != '0) ? fifo_mem[rd_ptr] : '0;
        r.head_data      = head[MAX_DATA_BITS-1:0];
        r.head_errors    = head[MAX_DATA_BITS+1:MAX_DATA_BITS];
        r.fifo_not_empty = (fill != '0);
        r.fill_level     = fill;
        r.overrun_flag   = overrun_q;
        r.level_irq      = irq;
        r.rts_out        = cfg_m.rts_enable & rts_q;
        r.word_done      = done;
        return r;
    endfunction

    function automatic string show(input result_t r);
        return $sformatf("data=%h err=%b ne=%b fill=%0d ovr=%b irq=%b rts=%b done=%b",
                         r.head_data, r.head_errors, r.fifo_not_empty, r.fill_level,
                         r.overrun_flag, r.level_irq, r.rts_out, r.word_done);
    endfunction

    function automatic int pick_wait(input int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 19);
            default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
        endcase
    endfunction

    function automatic void set_idle();
        send_mode = $urandom_range(0, 2);
        recv_mode = $urandom_range(0, 2);
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("tb_top: %s", msg);
    endtask

    // status beat checker and watchdog
    always @(posedge clk)
    begin : check_beats
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
            else if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[RESULT_W-1:0]);
                if (pending_status.size() == 0)
                    flag_error($sformatf("unexpected beat at %0t: %s", $time, show(got)));
                else
                begin
                    want = pending_status.pop_front();
                    if (got !== want)
                        flag_error($sformatf("mismatch at %0t\n  exp %s\n  got %s",
                                             $time, show(want), show(got)));
                end
            end
        end
    end

    // status sink
    initial
    begin : sink
        int w;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                w = hold_cycles;
                hold_cycles = 0;
            end
            else
                w = pick_wait(recv_mode);
            repeat (w)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic send_tick(input logic rx, input logic pop);
        int w;
        w = pick_wait(send_mode);
        repeat (w)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({pop, rx});
        do
            @(posedge clk);
        while (!s_tready);
        pending_status.push_back(next_status(rx, pop));
        ticks_sent++;
    endtask

    task automatic quiesce();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [TIMER_W-1:0] val);
        quiesce();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_TICKS_PER_BIT:    cfg_m.ticks_per_bit    = val;
            REG_DATA_BITS:        cfg_m.data_bits        = val[4:0];
            REG_PARITY_ENABLE:    cfg_m.parity_enable    = val[0];
            REG_PARITY_ODD:       cfg_m.parity_odd       = val[0];
            REG_IRQ_LEVEL:        cfg_m.irq_level        = val[3:0];
            REG_RTS_ENABLE:       cfg_m.rts_enable       = val[0];
            REG_RTS_HALT_LEVEL:   cfg_m.rts_halt_level   = val[3:0];
            REG_RTS_RESUME_LEVEL: cfg_m.rts_resume_level = val[3:0];
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // unused upper bits of narrow registers carry junk
    task automatic apply_cfg(input logic [TIMER_W-1:0] tpb, input logic [4:0] nbits,
                             input logic pe, input logic po, input logic [3:0] irq,
                             input logic rte, input logic [3:0] halt,
                             input logic [3:0] resume);
        cfg_write(REG_TICKS_PER_BIT, tpb);
        cfg_write(REG_DATA_BITS, TIMER_W'({$urandom(), nbits}));
        cfg_write(REG_PARITY_ENABLE, TIMER_W'({$urandom(), pe}));
        cfg_write(REG_PARITY_ODD, TIMER_W'({$urandom(), po}));
        cfg_write(REG_IRQ_LEVEL, TIMER_W'({$urandom(), irq}));
        cfg_write(REG_RTS_ENABLE, TIMER_W'({$urandom(), rte}));
        cfg_write(REG_RTS_HALT_LEVEL, TIMER_W'({$urandom(), halt}));
        cfg_write(REG_RTS_RESUME_LEVEL, TIMER_W'({$urandom(), resume}));
    endtask

    // one character on the line at the current settings, then one idle-high tick
    task automatic send_frame(input logic [15:0] word, input logic par_flip,
                              input logic stop_lvl, input int pop_pct, input int glitch_pct);
        int          nb;
        int          nbits;
        int          tbe;
        int          bi;
        logic [15:0] mask16;
        logic        par;
        logic        lvl;
        nb     = int'(eff_bits(cfg_m.data_bits));
        nbits  = nb + int'(cfg_m.parity_enable);
        tbe    = (cfg_m.ticks_per_bit == '0) ? 1 : int'(cfg_m.ticks_per_bit);
        mask16 = (nb >= 16) ? 16'hFFFF : 16'((1 << nb) - 1);
        par    = cfg_m.parity_odd ^ (^(word & mask16)) ^ par_flip;
        for (int i = 0; i < tbe * (nbits + 2); i++)
        begin
            bi = i / tbe;
            if (bi == 0)
                lvl = 1'b0;
            else if (bi <= nb)
                lvl = word[bi-1];
            else if (bi <= nbits)
                lvl = par;
            else
                lvl = stop_lvl;
            if (glitch_pct > 0 && $urandom_range(0, 99) < glitch_pct)
                lvl = ~lvl;
            send_tick(lvl, $urandom_range(0, 99) < pop_pct);
        end
        send_tick(1'b1, $urandom_range(0, 99) < pop_pct);
    endtask

    task automatic test_defaults();
        send_mode = 1;
        recv_mode = 1;
        repeat (3)
            send_tick(1'b1, 1'b1);
        send_mode = 0;
        send_frame(16'h00A5, 1'b0, 1'b1, 0, 0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
    endtask

    task automatic test_directed_frames();
        logic [7:0] w8;
        send_mode = 0;
        recv_mode = 1;
        // one tick per bit, widest word, odd parity, RTS halts at level 0
        apply_cfg(20'd1, 5'd16, 1'b1, 1'b1, 4'd0, 1'b1, 4'd0, 4'd15);
        send_frame(16'hFFFF, 1'b0, 1'b1, 0, 0);
        send_frame(16'h0000, 1'b1, 1'b1, 0, 0);
        send_frame(16'h8001, 1'b0, 1'b0, 0, 0);
        send_tick(1'b1, 1'b1);
        // zero bit time, parity-only frames, even parity
        apply_cfg(20'd0, 5'd0, 1'b1, 1'b0, 4'd15, 1'b1, 4'd15, 4'd0);
        send_frame(16'h0000, 1'b0, 1'b1, 50, 0);
        send_frame(16'h0000, 1'b1, 1'b0, 50, 0);
        send_tick(1'b1, 1'b0);
        // oversized data_bits clamps to 16
        apply_cfg(20'd2, 5'd31, 1'b0, 1'b0, 4'd2, 1'b0, 4'd15, 4'd15);
        send_frame(16'h5A3C, 1'b0, 1'b1, 30, 0);
        // width shrinks mid-frame: count kept, mask applied at push
        apply_cfg(20'd1, 5'd8, 1'b0, 1'b0, 4'd1, 1'b0, 4'd12, 4'd4);
        w8 = 8'hFF;
        send_tick(1'b0, 1'b0);
        for (int i = 0; i < 4; i++)
            send_tick(w8[i], 1'b0);
        cfg_write(REG_DATA_BITS, TIMER_W'(3));
        for (int i = 4; i < 8; i++)
            send_tick(w8[i], 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        // longest bit time, line kept idle
        apply_cfg(20'hFFFFF, 5'd8, 1'b1, 1'b1, 4'd3, 1'b1, 4'd1, 4'd0);
        repeat (20)
            send_tick(1'b1, 1'b1);
    endtask

    task automatic test_fill_overrun();
        set_idle();
        apply_cfg(20'd1, 5'd1, 1'b0, 1'b0, 4'd15, 1'b1, 4'd12, 4'd4);
        repeat (18)
            send_frame(16'($urandom_range(0, 1)), 1'b0, 1'b1, 0, 0);
        repeat (20)
            send_tick(1'b1, 1'b1);
    endtask

    task automatic test_random_traffic();
        int          start;
        int          pop_pct;
        int          r;
        logic [19:0] tpb;
        logic [4:0]  nb;
        for (int round = 0; round < 2; round++)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                tpb = 20'($urandom_range(0, 1));
            else if (r < 7)
                tpb = 20'($urandom_range(2, 4));
            else
                tpb = 20'($urandom_range(5, 12));
            r = $urandom_range(0, 7);
            if (r == 0)
                nb = 5'($urandom_range(17, 31));
            else if (r == 1)
                nb = 5'd0;
            else
                nb = 5'($urandom_range(1, 16));
            apply_cfg(tpb, nb, 1'($urandom()), 1'($urandom()), 4'($urandom()),
                      1'($urandom()), 4'($urandom()), 4'($urandom()));
            set_idle();
            case ($urandom_range(0, 3))
                0: pop_pct = 0;
                1: pop_pct = 5;
                2: pop_pct = 20;
                default: pop_pct = 50;
            endcase
            start = ticks_sent;
            while (ticks_sent - start < 20)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(1, 6))
                        send_tick(1'($urandom()), 1'($urandom()));
                end
                else
                    send_frame(16'($urandom()), $urandom_range(0, 7) == 0,
                               $urandom_range(0, 7) != 0, pop_pct,
                               ($urandom_range(0, 5) == 0) ? 5 : 0);
            end
        end
    endtask

    task automatic test_backpressure();
        int start;
        apply_cfg(20'd2, 5'd4, 1'b1, 1'b0, 4'd3, 1'b1, 4'd6, 4'd2);
        send_mode   = 0;
        recv_mode   = 1;
        hold_cycles = HOLD_LONG;
        start = ticks_sent;
        while (ticks_sent - start < 60)
            send_frame(16'($urandom()), 1'b0, 1'b1, 20, 0);
    endtask

    task automatic finish_run();
        quiesce();
        repeat (4)
            @(posedge clk);
        if (pending_status.size() != 0)
            flag_error("status beats missing at end");
        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_TICKS_PER_BIT;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        ticks_sent     = 0;
        send_mode      = 0;
        recv_mode      = 0;
        hold_cycles    = 0;
        reset_model();
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_defaults();
        test_directed_frames();
        test_fill_overrun();
        test_random_traffic();
        test_backpressure();
        finish_run();
    end

endmodule
